// File: hdl/ramn_pkg.sv
// ----------------------------------------------------------------------------
// ramn_pkg
// Shared widths, operation and message codes, and the compare result
// word for the Ricart-Agrawala mutual exclusion node.
// ----------------------------------------------------------------------------
package ramn_pkg;

   localparam int MAX_NODES         = 16;
   localparam int TICKET_WIDTH      = 32;
   localparam int ID_WIDTH          = 5;
   localparam int OP_WIDTH          = 2;
   localparam int KIND_WIDTH        = 2;
   localparam int CSR_INDEX_WIDTH   = 2;
   localparam int DEFER_ADDR_WIDTH  = $clog2(MAX_NODES);
   localparam int DEFER_COUNT_WIDTH = $clog2(MAX_NODES + 1);

   typedef enum logic [OP_WIDTH-1:0] {
      OP_LOCAL_REQUEST = 2'd0,
      OP_PEER_REQUEST  = 2'd1,
      OP_PEER_REPLY    = 2'd2,
      OP_RELEASE       = 2'd3
   } op_type;

   typedef enum logic [KIND_WIDTH-1:0] {
      KIND_REQUEST  = 2'd0,
      KIND_REPLY    = 2'd1,
      KIND_GRANT    = 2'd2,
      KIND_OVERFLOW = 2'd3
   } kind_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MY_ID      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NODE_COUNT = 2'd1;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_result_type;

endpackage

// File: hdl/ramn_if.sv
// ----------------------------------------------------------------------------
// ramn_if
// Valid/ready channels of the mutual exclusion node: request words in,
// message words out, and the register write channel.
// ----------------------------------------------------------------------------
interface ramn_req_if;
   logic                                valid;
   logic                                ready;
   logic [ramn_pkg::OP_WIDTH-1:0]       operation;
   logic [ramn_pkg::ID_WIDTH-1:0]       peer_id;
   logic [ramn_pkg::TICKET_WIDTH-1:0]   peer_ticket;
   modport source (output valid, operation, peer_id, peer_ticket, input ready);
   modport sink   (input valid, operation, peer_id, peer_ticket, output ready);
endinterface

interface ramn_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [ramn_pkg::KIND_WIDTH-1:0]     message_kind;
   logic [ramn_pkg::ID_WIDTH-1:0]       destination;
   logic [ramn_pkg::TICKET_WIDTH-1:0]   ticket_out;
   logic                                last;
   modport source (output valid, message_kind, destination, ticket_out, last, input ready);
   modport sink   (input valid, message_kind, destination, ticket_out, last, output ready);
endinterface

interface ramn_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [ramn_pkg::CSR_INDEX_WIDTH-1:0]   index;
   logic [ramn_pkg::ID_WIDTH-1:0]          data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/ricart_agrawala_mutex_node_core.sv
// ----------------------------------------------------------------------------
// ricart_agrawala_mutex_node_core
// One node of ticket-based distributed mutual exclusion (Ricart-Agrawala).
// ----------------------------------------------------------------------------
// Takes one request word at a time; req_ch.ready is high only while the node
// is idle. A local request steps through every node id from 1 to the node
// count, own id included, emitting a request word on each other id, then
// the grant word in a single-node system. A peer request uses the shared
// ticket comparator against the highest ticket, then against the own ticket,
// then defers the peer or sends a reply or overflow word. A peer reply that
// completes the grant goes on to the grant word. A release sends a reply to
// each deferred peer after a registered read of the deferred list. Each emitted
// word waits on rsp_ch.ready; a finished word may sit in the output register
// while the next request word is taken. Register writes on csr_ch are always
// taken; the user must keep them to idle periods, the block does not enforce it.
// ----------------------------------------------------------------------------
module ricart_agrawala_mutex_node_core (
   input  logic        clock,
   input  logic        reset,
   ramn_req_if.sink    req_ch,
   ramn_rsp_if.source  rsp_ch,
   ramn_csr_if.sink    csr_ch
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PEER_HIGH,
      S_PEER_OWN,
      S_SEND_REQ,
      S_SEND_ONE,
      S_READ_DEFER,
      S_SEND_DEFER
   } state_type;

   localparam int TW = ramn_pkg::TICKET_WIDTH;
   localparam int IW = ramn_pkg::ID_WIDTH;
   localparam int AW = ramn_pkg::DEFER_ADDR_WIDTH;
   localparam int CW = ramn_pkg::DEFER_COUNT_WIDTH;

   state_type                 state_ff, state_in;
   logic [IW-1:0]             my_id_ff, node_count_ff;
   logic [TW-1:0]             own_ticket_ff, own_ticket_in;
   logic [TW-1:0]             highest_ff, highest_in;
   logic                      wanting_ff, wanting_in;
   logic [IW-1:0]             replies_ff, replies_in;
   logic [CW-1:0]             defer_count_ff, defer_count_in;
   logic [IW-1:0]             peer_id_ff, peer_id_in;
   logic [TW-1:0]             peer_ticket_ff, peer_ticket_in;
   logic [IW-1:0]             idx_ff, idx_in;
   logic [AW-1:0]             rd_idx_ff, rd_idx_in;
   ramn_pkg::kind_type        one_kind_ff, one_kind_in;
   logic [IW-1:0]             one_dest_ff, one_dest_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   ramn_pkg::kind_type        rsp_kind_ff, rsp_kind_in;
   logic [IW-1:0]             rsp_dest_ff, rsp_dest_in;
   logic [TW-1:0]             rsp_ticket_ff, rsp_ticket_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_load;

   logic                      accept;
   logic                      space;
   logic [IW-1:0]             n_eff;
   logic [IW-1:0]             needed;
   logic                      last_req;
   logic                      defer_final;
   logic                      defer_wr_en;
   logic [IW-1:0]             defer_rd_data;
   logic [TW-1:0]             cmp_b;
   ramn_pkg::cmp_result_type  cmp_res;
   ramn_pkg::op_type          op;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign space        = !rsp_valid_ff || rsp_ch.ready;
   assign op           = ramn_pkg::op_type'(req_ch.operation);

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.message_kind = rsp_kind_ff;
   assign rsp_ch.destination  = rsp_dest_ff;
   assign rsp_ch.ticket_out   = rsp_ticket_ff;
   assign rsp_ch.last         = rsp_last_ff;

   always_comb begin
      priority if (node_count_ff == '0) begin
         n_eff = IW'(1);
      end else if (node_count_ff > IW'(ramn_pkg::MAX_NODES)) begin
         n_eff = IW'(ramn_pkg::MAX_NODES);
      end else begin
         n_eff = node_count_ff;
      end
   end

   assign needed      = n_eff - IW'(1);
   assign last_req    = (n_eff != IW'(1)) &&
                        ((idx_ff == n_eff) ||
                         ((idx_ff + IW'(1) == n_eff) && (my_id_ff == n_eff)));
   assign defer_final = (CW'(rd_idx_ff) + CW'(1)) == defer_count_ff;
   assign cmp_b       = (state_ff == S_PEER_HIGH) ? highest_ff : own_ticket_ff;

   ramn_cmp u_cmp (
      .a      (peer_ticket_ff),
      .b      (cmp_b),
      .result (cmp_res)
   );

   ramn_defer u_defer (
      .clock      (clock),
      .wr_en      (defer_wr_en),
      .wr_addr    (defer_count_ff[AW-1:0]),
      .wr_data    (peer_id_ff),
      .rd_addr    (rd_idx_ff),
      .rd_data_ff (defer_rd_data)
   );

   always_comb begin
      state_in       = state_ff;
      own_ticket_in  = own_ticket_ff;
      highest_in     = highest_ff;
      wanting_in     = wanting_ff;
      replies_in     = replies_ff;
      defer_count_in = defer_count_ff;
      peer_id_in     = peer_id_ff;
      peer_ticket_in = peer_ticket_ff;
      idx_in         = idx_ff;
      rd_idx_in      = rd_idx_ff;
      one_kind_in    = one_kind_ff;
      one_dest_in    = one_dest_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_dest_in    = rsp_dest_ff;
      rsp_ticket_in  = rsp_ticket_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_load       = 1'b0;
      defer_wr_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               peer_id_in     = req_ch.peer_id;
               peer_ticket_in = req_ch.peer_ticket;
               unique case (op)
                  ramn_pkg::OP_LOCAL_REQUEST: begin
                     own_ticket_in = highest_ff;
                     highest_in    = highest_ff + TW'(1);
                     wanting_in    = 1'b1;
                     replies_in    = '0;
                     idx_in        = IW'(1);
                     state_in      = S_SEND_REQ;
                  end
                  ramn_pkg::OP_PEER_REQUEST: begin
                     state_in = S_PEER_HIGH;
                  end
                  ramn_pkg::OP_PEER_REPLY: begin
                     if (wanting_ff && (replies_ff < needed)) begin
                        replies_in = replies_ff + IW'(1);
                        if (replies_ff + IW'(1) == needed) begin
                           one_kind_in = ramn_pkg::KIND_GRANT;
                           one_dest_in = '0;
                           state_in    = S_SEND_ONE;
                        end
                     end
                  end
                  ramn_pkg::OP_RELEASE: begin
                     wanting_in = 1'b0;
                     replies_in = '0;
                     rd_idx_in  = '0;
                     if (defer_count_ff != '0) begin
                        state_in = S_READ_DEFER;
                     end
                  end
               endcase
            end
         end
         S_PEER_HIGH: begin
            if (!cmp_res.lt && !cmp_res.eq) begin
               highest_in = peer_ticket_ff;
            end
            state_in = S_PEER_OWN;
         end
         S_PEER_OWN: begin
            if (!wanting_ff || cmp_res.lt || (cmp_res.eq && (peer_id_ff < my_id_ff))) begin
               one_kind_in = ramn_pkg::KIND_REPLY;
               one_dest_in = peer_id_ff;
               state_in    = S_SEND_ONE;
            end else if (defer_count_ff < CW'(ramn_pkg::MAX_NODES)) begin
               defer_wr_en    = 1'b1;
               defer_count_in = defer_count_ff + CW'(1);
               state_in       = S_IDLE;
            end else begin
               one_kind_in = ramn_pkg::KIND_OVERFLOW;
               one_dest_in = '0;
               state_in    = S_SEND_ONE;
            end
         end
         S_SEND_REQ: begin
            if ((idx_ff != my_id_ff) && space) begin
               rsp_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = ramn_pkg::KIND_REQUEST;
               rsp_dest_in   = idx_ff;
               rsp_ticket_in = own_ticket_ff;
               rsp_last_in   = last_req;
            end
            if ((idx_ff == my_id_ff) || space) begin
               if (idx_ff == n_eff) begin
                  if (n_eff == IW'(1)) begin
                     one_kind_in = ramn_pkg::KIND_GRANT;
                     one_dest_in = '0;
                     state_in    = S_SEND_ONE;
                  end else begin
                     state_in = S_IDLE;
                  end
               end else begin
                  idx_in = idx_ff + IW'(1);
               end
            end
         end
         S_SEND_ONE: begin
            if (space) begin
               rsp_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = one_kind_ff;
               rsp_dest_in   = one_dest_ff;
               rsp_ticket_in = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_READ_DEFER: begin
            state_in = S_SEND_DEFER;
         end
         S_SEND_DEFER: begin
            if (space) begin
               rsp_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = ramn_pkg::KIND_REPLY;
               rsp_dest_in   = defer_rd_data;
               rsp_ticket_in = '0;
               rsp_last_in   = defer_final;
               if (defer_final) begin
                  defer_count_in = '0;
                  state_in       = S_IDLE;
               end else begin
                  rd_idx_in = rd_idx_ff + AW'(1);
                  state_in  = S_READ_DEFER;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      peer_id_ff     <= peer_id_in;
      peer_ticket_ff <= peer_ticket_in;
      idx_ff         <= idx_in;
      rd_idx_ff      <= rd_idx_in;
      one_kind_ff    <= one_kind_in;
      one_dest_ff    <= one_dest_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_dest_ff    <= rsp_dest_in;
      rsp_ticket_ff  <= rsp_ticket_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         my_id_ff       <= IW'(1);
         node_count_ff  <= IW'(2);
         own_ticket_ff  <= '0;
         highest_ff     <= '0;
         wanting_ff     <= 1'b0;
         replies_ff     <= '0;
         defer_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         own_ticket_ff  <= own_ticket_in;
         highest_ff     <= highest_in;
         wanting_ff     <= wanting_in;
         replies_ff     <= replies_in;
         defer_count_ff <= defer_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == ramn_pkg::CSR_MY_ID) begin
               my_id_ff <= csr_ch.data;
            end
            if (csr_ch.index == ramn_pkg::CSR_NODE_COUNT) begin
               node_count_ff <= csr_ch.data;
            end
         end
      end
   end

   a_defer_bound: assert property (@(posedge clock) disable iff (reset)
      defer_count_ff <= CW'(ramn_pkg::MAX_NODES))
      else $error("deferred count beyond list depth");

   a_skip_own: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND_REQ && rsp_load) |-> (idx_ff != my_id_ff))
      else $error("request word sent to own id");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.operation == ramn_pkg::OP_RELEASE) |=>
         (!wanting_ff && replies_ff == '0))
      else $error("release left wanting or reply count set");

   a_read_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEND_DEFER) |-> (CW'(rd_idx_ff) < defer_count_ff))
      else $error("deferred list read beyond fill count");

endmodule

// File: hdl/ramn_cmp.sv
// ----------------------------------------------------------------------------
// ramn_cmp
// Shared ticket comparator: unsigned less-than and equality of two tickets.
// ----------------------------------------------------------------------------
module ramn_cmp (
   input  logic [ramn_pkg::TICKET_WIDTH-1:0] a,
   input  logic [ramn_pkg::TICKET_WIDTH-1:0] b,
   output ramn_pkg::cmp_result_type          result
);

   assign result.lt = (a < b);
   assign result.eq = (a == b);

endmodule

// File: hdl/ramn_defer.sv
// ----------------------------------------------------------------------------
// ramn_defer
// Deferred peer list: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ramn_defer (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [ramn_pkg::DEFER_ADDR_WIDTH-1:0] wr_addr,
   input  logic [ramn_pkg::ID_WIDTH-1:0]         wr_data,
   input  logic [ramn_pkg::DEFER_ADDR_WIDTH-1:0] rd_addr,
   output logic [ramn_pkg::ID_WIDTH-1:0]         rd_data_ff
);

   logic [ramn_pkg::ID_WIDTH-1:0] mem [ramn_pkg::MAX_NODES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

endmodule

// File: tb/ramn_node_checker.sv
// ----------------------------------------------------------------------------
// ramn_node_checker
// Watches the request, message and register channels of the mutual
// exclusion node. It keeps its own copy of the node state (tickets, wanting
// flag, reply count, deferred list) and of the two registers. For every
// request word taken it predicts the message words the node must send. It
// then matches each message word taken on the output against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module ramn_node_checker (
   input  logic clock,
   input  logic reset,
   ramn_req_if  req_ch,
   ramn_rsp_if  rsp_ch,
   ramn_csr_if  csr_ch,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IW = ramn_pkg::ID_WIDTH;
   localparam int TW = ramn_pkg::TICKET_WIDTH;
   localparam int MN = ramn_pkg::MAX_NODES;

   typedef struct {
      ramn_pkg::kind_type   kind;
      logic [IW-1:0]        dest;
      logic [TW-1:0]        ticket;
      logic                 last;
   } message_type;

   message_type               outgoing_q[$];
   int                        errors;

   logic [IW-1:0]             my_id;
   logic [IW-1:0]             node_count;
   logic [TW-1:0]             own_ticket;
   logic [TW-1:0]             highest_ticket;
   logic                      wanting;
   int                        replies_seen;
   logic [IW-1:0]             deferred_ids [MN];
   int                        deferred_count;

   task automatic node_messages(ramn_pkg::op_type op, logic [IW-1:0] pid,
                                logic [TW-1:0] tk);
      message_type batch[$];
      int          n;
      int          needed;
      n = (node_count == 0) ? 1 : (node_count > MN) ? MN : int'(node_count);
      needed = n - 1;
      case (op)
         ramn_pkg::OP_LOCAL_REQUEST: begin
            own_ticket = highest_ticket;
            highest_ticket = highest_ticket + 1;
            wanting = 1'b1;
            replies_seen = 0;
            for (int i = 1; i <= n; i++)
               if (i != my_id)
                  batch.push_back('{ramn_pkg::KIND_REQUEST, IW'(i), own_ticket, 1'b0});
            if (needed == 0)
               batch.push_back('{ramn_pkg::KIND_GRANT, '0, '0, 1'b0});
         end
         ramn_pkg::OP_PEER_REQUEST: begin
            if (tk > highest_ticket)
               highest_ticket = tk;
            if (!wanting || tk < own_ticket || (tk == own_ticket && pid < my_id)) begin
               batch.push_back('{ramn_pkg::KIND_REPLY, pid, '0, 1'b0});
            end else if (deferred_count < MN) begin
               deferred_ids[deferred_count] = pid;
               deferred_count++;
            end else begin
               batch.push_back('{ramn_pkg::KIND_OVERFLOW, '0, '0, 1'b0});
            end
         end
         ramn_pkg::OP_PEER_REPLY: begin
            if (wanting && replies_seen < needed) begin
               replies_seen++;
               if (replies_seen == needed)
                  batch.push_back('{ramn_pkg::KIND_GRANT, '0, '0, 1'b0});
            end
         end
         default: begin
            wanting = 1'b0;
            replies_seen = 0;
            for (int i = 0; i < deferred_count; i++)
               batch.push_back('{ramn_pkg::KIND_REPLY, deferred_ids[i], '0, 1'b0});
            deferred_count = 0;
         end
      endcase
      if (batch.size() > 0)
         batch[batch.size()-1].last = 1'b1;
      foreach (batch[i])
         outgoing_q.push_back(batch[i]);
   endtask

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   task automatic check_message();
      message_type want;
      if (outgoing_q.size() == 0) begin
         $error("unexpected word: message_kind %0d destination %0d ticket_out %0h last %0b",
                rsp_ch.message_kind, rsp_ch.destination, rsp_ch.ticket_out, rsp_ch.last);
         errors++;
      end else begin
         want = outgoing_q.pop_front();
         compare_field("message_kind", 32'(want.kind), 32'(rsp_ch.message_kind));
         compare_field("destination", 32'(want.dest), 32'(rsp_ch.destination));
         compare_field("ticket_out", want.ticket, rsp_ch.ticket_out);
         compare_field("last", 32'(want.last), 32'(rsp_ch.last));
      end
   endtask

   initial begin
      errors = 0;
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         my_id = 1;
         node_count = 2;
         own_ticket = '0;
         highest_ticket = '0;
         wanting = 1'b0;
         replies_seen = 0;
         deferred_count = 0;
         outgoing_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_message();
         if (csr_ch.valid && csr_ch.ready) begin
            if (csr_ch.index == ramn_pkg::CSR_MY_ID)
               my_id = csr_ch.data;
            else if (csr_ch.index == ramn_pkg::CSR_NODE_COUNT)
               node_count = csr_ch.data;
         end
         if (req_ch.valid && req_ch.ready)
            node_messages(ramn_pkg::op_type'(req_ch.operation), req_ch.peer_id,
                          req_ch.peer_ticket);
      end
      fail_count <= errors;
      pending <= outgoing_q.size();
   end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the mutual exclusion node. A directed run walks
// through ticket wrap, equal tickets, deferral, grant, stray replies and
// repeated requests. Random rounds then follow over several node settings,
// the out-of-range ones among them: request, peer traffic, replies and
// release, mixed with noise words and deferral floods. Both sides idle at
// random, and the receiver once holds off long enough to stall the node.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IW = ramn_pkg::ID_WIDTH;
   localparam int TW = ramn_pkg::TICKET_WIDTH;
   localparam int MN = ramn_pkg::MAX_NODES;

   logic                  clock;
   logic                  reset;
   int                    fail_count;
   int                    pending;
   int                    words_sent;
   bit                    calm;
   int                    hold_offs_wanted;
   int                    hold_offs_done;
   logic [IW-1:0]         cfg_count;

   ramn_req_if req_ch ();
   ramn_rsp_if rsp_ch ();
   ramn_csr_if csr_ch ();

   ricart_agrawala_mutex_node_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   ramn_node_checker watch (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("status: fail");
      $finish;
   end

   function automatic int live_nodes();
      return (cfg_count == 0) ? 1 : (cfg_count > MN) ? MN : int'(cfg_count);
   endfunction

   function automatic logic [IW-1:0] pick_peer();
      if ($urandom_range(99) < 70)
         return IW'($urandom_range(1, live_nodes()));
      return IW'($urandom_range(0, 31));
   endfunction

   function automatic logic [TW-1:0] pick_ticket();
      case ($urandom_range(0, 4))
         0:       return '1;
         1:       return TW'($urandom_range(0, 15));
         2:       return 32'hFFFF_FFF0 | TW'($urandom_range(0, 15));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(ramn_pkg::op_type op, logic [IW-1:0] pid,
                            logic [TW-1:0] tk);
      while (!calm && $urandom_range(99) < 24) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.peer_id <= pid;
      req_ch.peer_ticket <= tk;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic configure(logic [IW-1:0] id, logic [IW-1:0] count);
      cfg_count = count;
      csr_ch.valid <= 1'b1;
      csr_ch.index <= ramn_pkg::CSR_MY_ID;
      csr_ch.data <= id;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.index <= ramn_pkg::CSR_NODE_COUNT;
      csr_ch.data <= count;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic drain_node();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic run_rounds(int words, bit flood_first);
      int stop_at;
      int peers;
      int replies;
      int needed;
      bit flood;
      stop_at = words_sent + words;
      needed = live_nodes() - 1;
      flood = flood_first;
      while (words_sent < stop_at) begin
         if ($urandom_range(99) < 15) begin
            send_word(ramn_pkg::op_type'($urandom_range(0, 3)), IW'($urandom), $urandom);
         end else begin
            send_word(ramn_pkg::OP_LOCAL_REQUEST, IW'($urandom), $urandom);
            if ($urandom_range(99) < 15)
               send_word(ramn_pkg::OP_LOCAL_REQUEST, IW'($urandom), $urandom);
            peers = flood ? $urandom_range(17, 19) : $urandom_range(0, 3);
            replies = ($urandom_range(99) < 15) ? $urandom_range(0, needed)
                                                : needed + $urandom_range(0, 1);
            while (peers + replies > 0) begin
               if (peers > 0 && (replies == 0 || $urandom_range(1) == 0)) begin
                  send_word(ramn_pkg::OP_PEER_REQUEST, pick_peer(),
                            flood ? '1 : pick_ticket());
                  peers--;
               end else begin
                  send_word(ramn_pkg::OP_PEER_REPLY, pick_peer(), $urandom);
                  replies--;
               end
            end
            if ($urandom_range(99) < 90)
               send_word(ramn_pkg::OP_RELEASE, IW'($urandom), $urandom);
            flood = ($urandom_range(99) < 8);
         end
      end
   endtask

   initial begin : message_sink
      int held;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_offs_done < hold_offs_wanted) begin
            hold_offs_done++;
            rsp_ch.ready <= 1'b0;
            for (held = 0; held < 200; held++) @(posedge clock);
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= 24);
         end
      end
   end

   initial begin : stimulus
      words_sent = 0;
      calm = 1'b0;
      hold_offs_wanted = 0;
      hold_offs_done = 0;
      cfg_count = 2;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.operation <= ramn_pkg::OP_LOCAL_REQUEST;
      req_ch.peer_id <= '0;
      req_ch.peer_ticket <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= ramn_pkg::CSR_MY_ID;
      csr_ch.data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      configure(5'd2, 5'd4);
      send_word(ramn_pkg::OP_RELEASE, 5'd0, 32'd0);
      send_word(ramn_pkg::OP_PEER_REPLY, 5'd3, 32'd0);
      send_word(ramn_pkg::OP_PEER_REQUEST, 5'd1, 32'd0);
      send_word(ramn_pkg::OP_PEER_REQUEST, 5'd31, 32'hFFFF_FFFF);
      send_word(ramn_pkg::OP_LOCAL_REQUEST, 5'd0, 32'd0);
      send_word(ramn_pkg::OP_PEER_REQUEST, 5'd3, 32'hFFFF_FFFF);
      send_word(ramn_pkg::OP_PEER_REQUEST, 5'd1, 32'hFFFF_FFFF);
      send_word(ramn_pkg::OP_PEER_REQUEST, 5'd0, 32'd5);
      send_word(ramn_pkg::OP_PEER_REQUEST, 5'd16, 32'hFFFF_FFFF);
      send_word(ramn_pkg::OP_PEER_REPLY, 5'd1, 32'd0);
      send_word(ramn_pkg::OP_PEER_REPLY, 5'd3, 32'd0);
      send_word(ramn_pkg::OP_PEER_REPLY, 5'd4, 32'd0);
      send_word(ramn_pkg::OP_PEER_REPLY, 5'd4, 32'd0);
      send_word(ramn_pkg::OP_RELEASE, 5'd31, 32'hFFFF_FFFF);
      send_word(ramn_pkg::OP_LOCAL_REQUEST, 5'd31, 32'hFFFF_FFFF);
      send_word(ramn_pkg::OP_PEER_REPLY, 5'd1, 32'd0);
      send_word(ramn_pkg::OP_LOCAL_REQUEST, 5'd0, 32'd0);
      send_word(ramn_pkg::OP_PEER_REQUEST, 5'd4, 32'd0);
      send_word(ramn_pkg::OP_RELEASE, 5'd0, 32'd0);
      drain_node();

      configure(5'd1, 5'd1);
      run_rounds(30, 1'b0);
      drain_node();

      hold_offs_wanted++;
      configure(5'd16, 5'd16);
      run_rounds(30, 1'b0);
      drain_node();

      configure(5'd0, 5'd0);
      run_rounds(30, 1'b1);
      drain_node();

      calm = 1'b1;
      configure(5'd5, 5'd9);
      run_rounds(30, 1'b0);
      drain_node();
      calm = 1'b0;

      configure(5'd31, 5'd31);
      run_rounds(30, 1'b0);
      drain_node();

      configure(5'd3, 5'd2);
      run_rounds(30, 1'b0);
      drain_node();

      configure(5'd10, 5'd21);
      run_rounds(30, 1'b1);
      drain_node();

      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
